[rtl/core/ddlcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddlcd_pkg
// Shared constants and types for the decimal-to-LCD nibble converter.
// ----------------------------------------------------------------------------
package ddlcd_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_DIGITS = 10;

	localparam int IN_W  = 31;
	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam int TOP_W = $clog2(MAX_DIGITS);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ = 4'd3;
	localparam logic [3:0] DIGIT_MAX = 4'd9;

	typedef logic [MAX_DIGITS-1:0][3:0] digit_vec_t;

	typedef struct packed {
		digit_vec_t        digits;
		logic [TOP_W-1:0]  top;
	} num_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_CONV,
		FS_PUSH
	} front_state_t;

endpackage

[rtl/core/ddlcd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddlcd_front
// Accepts a value, converts it to BCD by shift-and-add-3, one bit a cycle,
// finds the top significant digit and pushes the result to the queue.
// ----------------------------------------------------------------------------
module ddlcd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ddlcd_pkg::IN_W-1:0]   value,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic                         push,
	output ddlcd_pkg::num_t              push_data,
	input  logic                         q_full
);
	import ddlcd_pkg::*;

	front_state_t           state_q, state_d;
	logic [VALUE_BITS-1:0]  sr_q;
	digit_vec_t             bcd_q;
	digit_vec_t             bcd_adj;
	logic [CNT_W-1:0]       cnt_q;
	logic [TOP_W-1:0]       top;
	logic                   accept;

	assign accept = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= BCD_ADJ_MIN) ? bcd_q[i] + BCD_ADJ : bcd_q[i];
		end
	end

	always_comb begin
		top = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				top = TOP_W'(i);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		push     = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = FS_CONV;
				end
			end
			FS_CONV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = FS_PUSH;
				end
			end
			FS_PUSH: begin
				if (!q_full) begin
					push    = 1'b1;
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	assign push_data.digits = bcd_q;
	assign push_data.top    = top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= CNT_W'(VALUE_BITS);
			end else if (state_q == FS_CONV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sr_q  <= VALUE_BITS'(value);
			bcd_q <= '0;
		end else if (state_q == FS_CONV) begin
			// top digit carry drops out: keeps value mod 10^MAX_DIGITS
			bcd_q <= (MAX_DIGITS*4)'({bcd_adj, sr_q[VALUE_BITS-1]});
			sr_q  <= {sr_q[VALUE_BITS-2:0], 1'b0};
		end
	end

endmodule

[rtl/core/ddlcd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddlcd_queue
// Two-entry queue of converted numbers between front and back.
// ----------------------------------------------------------------------------
module ddlcd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ddlcd_pkg::num_t  push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output ddlcd_pkg::num_t  pop_data
);
	import ddlcd_pkg::*;

	num_t        mem [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/core/ddlcd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddlcd_back
// Walks a number's digits from the top one down and sends each character
// as upper then lower nibble through an output register.
// ----------------------------------------------------------------------------
module ddlcd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  ddlcd_pkg::num_t  q_data,
	output logic             pop,
	output logic [3:0]       nibble,
	output logic             upper_half,
	output logic             last,
	output logic             out_valid,
	input  logic             out_stall
);
	import ddlcd_pkg::*;

	logic              busy_q;
	digit_vec_t        digits_q;
	logic [TOP_W-1:0]  pos_q;
	logic              upper_q;
	logic              load_out;
	logic              gen;
	logic [3:0]        digit;

	logic              out_valid_q;
	logic [3:0]        nibble_q;
	logic              upper_half_q;
	logic              last_q;

	assign load_out = !out_valid_q || !out_stall;
	assign gen      = busy_q && load_out;
	assign pop      = !busy_q && !q_empty;
	assign digit    = digits_q[pos_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (gen && !upper_q && pos_q == '0) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			digits_q <= q_data.digits;
			pos_q    <= q_data.top;
			upper_q  <= 1'b1;
		end else if (gen) begin
			upper_q <= ~upper_q;
			if (!upper_q) begin
				pos_q <= pos_q - TOP_W'(1);
			end
		end
		if (gen) begin
			upper_half_q <= upper_q;
			if (upper_q) begin
				nibble_q <= ASCII_ZERO[7:4];
				last_q   <= 1'b0;
			end else begin
				nibble_q <= ASCII_ZERO[3:0] + digit;
				last_q   <= (pos_q == '0);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign nibble     = nibble_q;
	assign upper_half = upper_half_q;
	assign last       = last_q;

endmodule

[rtl/core/decimal_digits_to_lcd_nibbles.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digits_to_lcd_nibbles
// Integer in, decimal ASCII characters out as 4-bit LCD data transfers.
//
// Input channel: value with in_valid / in_stall. A word is taken when
// in_valid is high and in_stall low. Output channel: nibble, upper_half and
// last with out_valid / out_stall; a run of transfers per accepted word.
// Each digit goes out as two transfers, upper nibble (0x3) first, then the
// digit; last marks the lower nibble of the final digit. Leading zeros are
// dropped; zero gives one digit.
// The front takes the value, runs the shift-and-add-3 conversion over all
// VALUE_BITS bits (one value bit per cycle) and then queues it; the back
// pops it and sends the first transfer through its output register.
// The front takes no new value until the current one is queued. The back
// sends up to 20 transfers, one per cycle unless out_stall holds it, and
// overlaps with the next conversion through a two-entry queue.
// Reset clears the state machines, queue pointers and output valid; no word is pending afterwards.
// A stall on the output holds the current transfer; once the queue fills,
// the front stops taking new values.
// ----------------------------------------------------------------------------
module decimal_digits_to_lcd_nibbles (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ddlcd_pkg::IN_W-1:0]  value,
	input  logic                        in_valid,
	output logic                        in_stall,
	output logic [3:0]                  nibble,
	output logic                        upper_half,
	output logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall
);
	import ddlcd_pkg::*;

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	num_t  push_data;
	num_t  pop_data;

	ddlcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ddlcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	ddlcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (pop_data),
		.pop        (pop),
		.nibble     (nibble),
		.upper_half (upper_half),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

[rtl/core/ddlcd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddlcd_checker
// Port-level checks on the transfer stream, bound to the top level.
// ----------------------------------------------------------------------------
module ddlcd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  nibble,
	input  logic        upper_half,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_stall
);
	import ddlcd_pkg::*;

	a_last_on_lower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !upper_half)
		else $error("last set on an upper nibble");

	a_upper_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && upper_half |-> nibble == ASCII_ZERO[7:4])
		else $error("upper nibble is not the digit prefix");

	a_lower_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !upper_half |-> nibble <= DIGIT_MAX)
		else $error("lower nibble is not a decimal digit");

	a_upper_then_lower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && upper_half ##1 out_valid |-> !upper_half)
		else $error("upper nibble not followed by its lower nibble");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nibble) && $stable(last))
		else $error("stalled transfer changed");

endmodule

bind decimal_digits_to_lcd_nibbles ddlcd_checker u_ddlcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.nibble     (nibble),
	.upper_half (upper_half),
	.last       (last),
	.out_valid  (out_valid),
	.out_stall  (out_stall)
);
